@@ sv/tsam_pkg.sv @@
// shared types and constants for the topological sort block
`timescale 1ns / 1ps

package tsam_pkg;

  // field widths fixed by the interface
  localparam int ROW_W      = 8;
  localparam int CFG_W      = 4;
  localparam int NODE_IDX_W = 3;
  // widest graph the row and index fields can describe
  localparam int MAX_LANES  = 8;
  // node count after reset
  localparam logic [CFG_W-1:0] NODES_RST = 4'd8;

  // input transaction
  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             last_row;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [NODE_IDX_W-1:0] node_index;
    logic                  cycle_error;
    logic                  last_result;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // accept one row
    logic cfg_we;     // write node count
    logic step;       // one sort step
    logic step_last;  // this step gives the final result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic             found;  // some node is ready to go out
    logic [CFG_W-1:0] n_eff;  // clamped node count
  } stat_t;

endpackage

@@ sv/tsam_dp.sv @@
// datapath: adjacency rows, in-degree counters, chosen marks and result register
`timescale 1ns / 1ps

module tsam_dp #(
  parameter int ROWS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tsam_pkg::cmd_t  cmd,
  input  tsam_pkg::in_t   in_data,
  input  logic [tsam_pkg::CFG_W-1:0] cfg_data,
  output tsam_pkg::stat_t stat,
  output tsam_pkg::out_t  out_data
);

  localparam int IDX_W = $clog2(ROWS);

  logic [tsam_pkg::CFG_W-1:0] nodes_r;
  logic [tsam_pkg::CFG_W-1:0] cnt_r, cnt_nxt;
  logic [tsam_pkg::CFG_W-1:0] n_eff;
  logic [ROWS-1:0]            adj_r [ROWS];
  logic [ROWS-1:0]            adj_nxt [ROWS];
  logic [3:0]                 deg_r [ROWS];
  logic [3:0]                 deg_nxt [ROWS];
  logic [ROWS-1:0]            chosen_r, chosen_nxt;
  logic [ROWS-1:0]            col_en;
  logic [ROWS-1:0]            cand;
  logic [IDX_W-1:0]           pick;
  logic                       found;
  logic [ROWS-1:0]            pick_row;
  logic                       load_clear;
  logic                       row_take;
  tsam_pkg::out_t             out_r;

  // clamp the node count into 1..ROWS
  always_comb begin
    priority if (nodes_r == '0) begin
      n_eff = tsam_pkg::CFG_W'(1);
    end else if (nodes_r > tsam_pkg::CFG_W'(ROWS)) begin
      n_eff = tsam_pkg::CFG_W'(ROWS);
    end else begin
      n_eff = nodes_r;
    end
  end

  // columns in use, ready nodes and lowest-numbered pick
  always_comb begin
    pick = '0;
    for (int j = 0; j < ROWS; j++) begin
      col_en[j] = tsam_pkg::CFG_W'(j) < n_eff;
      cand[j]   = col_en[j] && !chosen_r[j] && (deg_r[j] == 4'd0);
    end
    for (int j = ROWS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick = IDX_W'(j);
      end
    end
    found    = |cand;
    pick_row = adj_r[pick];
  end

  assign load_clear = cmd.load && (cnt_r == '0);
  // rows past the node count are dropped
  assign row_take   = cnt_r < n_eff;

  // next state of the stores
  always_comb begin
    cnt_nxt    = cnt_r;
    chosen_nxt = chosen_r;
    adj_nxt    = adj_r;
    deg_nxt    = deg_r;
    if (cmd.load) begin
      // a new load clears the stores, then the row adds its edges
      for (int j = 0; j < ROWS; j++) begin
        deg_nxt[j]    = (load_clear ? 4'd0 : deg_r[j])
                        + 4'(in_data.row_bits[j] & col_en[j] & row_take);
        chosen_nxt[j] = load_clear ? 1'b0 : chosen_r[j];
        if (load_clear) begin
          adj_nxt[j] = '0;
        end
      end
      if (row_take) begin
        adj_nxt[cnt_r[IDX_W-1:0]] = in_data.row_bits[ROWS-1:0] & col_en;
        cnt_nxt = cnt_r + tsam_pkg::CFG_W'(1);
      end
      if (in_data.last_row) begin
        cnt_nxt = '0;
      end
    end else if (cmd.step && found) begin
      // retire the picked node and release its successors
      chosen_nxt[pick] = 1'b1;
      adj_nxt[pick]    = '0;
      for (int j = 0; j < ROWS; j++) begin
        if (pick_row[j] && col_en[j] && (deg_r[j] != 4'd0)) begin
          deg_nxt[j] = deg_r[j] - 4'd1;
        end
      end
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r  <= tsam_pkg::NODES_RST;
      cnt_r    <= '0;
      chosen_r <= '0;
      for (int j = 0; j < ROWS; j++) begin
        deg_r[j] <= 4'd0;
      end
    end else begin
      if (cmd.cfg_we) begin
        nodes_r <= cfg_data;
      end
      cnt_r    <= cnt_nxt;
      chosen_r <= chosen_nxt;
      deg_r    <= deg_nxt;
    end
  end

  // row store and result payload
  always_ff @(posedge clk) begin
    adj_r <= adj_nxt;
    if (cmd.step) begin
      if (found) begin
        out_r.node_index  <= tsam_pkg::NODE_IDX_W'(pick);
        out_r.cycle_error <= 1'b0;
        out_r.last_result <= cmd.step_last;
      end else begin
        out_r.node_index  <= '0;
        out_r.cycle_error <= 1'b1;
        out_r.last_result <= 1'b1;
      end
    end
  end

  assign stat.found = found;
  assign stat.n_eff = n_eff;
  assign out_data   = out_r;

endmodule

@@ sv/tsam_ctrl.sv @@
// controller: load and sort sequencing, step counter and result strobe
`timescale 1ns / 1ps

module tsam_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            row_last,
  input  logic            cfg_valid,
  input  tsam_pkg::stat_t stat,
  output tsam_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            cfg_ready,
  output logic            out_valid
);

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_t;

  state_t     state_r;
  logic [2:0] step_r;
  logic       out_valid_r;

  assign busy      = (state_r == ST_SORT);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;

  // commands to the datapath
  always_comb begin
    cmd.load      = start && !busy;
    cmd.cfg_we    = cfg_valid && !busy;
    cmd.step      = busy;
    cmd.step_last = !stat.found
                    || ({1'b0, step_r} == (stat.n_eff - tsam_pkg::CFG_W'(1)));
  end

  // state, step count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.step;
      unique case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (cmd.load && row_last) begin
            state_r <= ST_SORT;
          end
        end
        ST_SORT: begin
          if (cmd.step_last) begin
            state_r <= ST_IDLE;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/topological_sort_adjacency_matrix.sv @@
// top level of the adjacency-matrix topological sort
`timescale 1ns / 1ps

// Loads a directed graph one adjacency row per input transaction and emits
// its nodes in topological order, lowest-numbered ready node first.
// Input: a transaction is taken on a rising edge with start high and busy
//   low; rows are taken back to back, one per cycle, while busy is low.
//   The row marked last_row starts the sort and raises busy.
// Sort: one node per cycle from a priority pick over the in-degree
//   counters; taking the last row sets the sort state, and each result is
//   then registered into out_data; busy stays high until the final result
//   (at most the node count of results). A cycle in the graph ends the
//   sort with one error result.
// Output: each result is on out_data for one cycle with out_valid high;
//   the receiver cannot stall, so nothing is ever held back.
// Config: cfg_data sets the node count, written when cfg_valid and
//   cfg_ready are high; cfg_ready is low while the sort runs.
// Reset: counters and marks clear, the node count returns to eight, and
//   the block is ready as soon as reset is released.
module topological_sort_adjacency_matrix #(
  parameter int NODES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  tsam_pkg::in_t              in_data,
  output logic                       out_valid,
  output tsam_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tsam_pkg::CFG_W-1:0] cfg_data
);

  localparam int LANES = (NODES < tsam_pkg::MAX_LANES) ? NODES : tsam_pkg::MAX_LANES;

  tsam_pkg::cmd_t  cmd;
  tsam_pkg::stat_t stat;

  // sequencing
  tsam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .row_last  (in_data.last_row),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid)
  );

  // graph stores and result register
  tsam_dp #(
    .ROWS (LANES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // an error result is always the final one and carries node zero
  a_err_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cycle_error |->
      out_data.last_result && (out_data.node_index == '0))
    else $error("error result not marked last");

  // every result comes from a sort cycle
  a_res_from_sort : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a sort cycle");

  // the sort only starts on an accepted last row
  a_sort_start : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_data.last_row))
    else $error("sort started without a last row");

  // the final result releases the block
  a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> !busy)
    else $error("still busy after final result");
`endif

endmodule
